FILE: sv/clipped_gradient_rect_fill_core_assert.svh
// assertion macros for the clipped gradient rectangle fill core
`ifndef CLIPPED_GRADIENT_RECT_FILL_CORE_ASSERT_SVH
`define CLIPPED_GRADIENT_RECT_FILL_CORE_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication, checked on every rising edge out of reset
`define CGRF_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cgrf assertion failed");
// next-cycle implication
`define CGRF_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cgrf assertion failed");
`else
`define CGRF_ASSERT_IMP(label, ante, cons)
`define CGRF_ASSERT_NXT(label, ante, cons)
`endif
`endif

FILE: sv/cgrf_pkg.sv
// shared constants and types of the clipped gradient rectangle fill core
package cgrf_pkg;

  localparam int unsigned MAX_SURFACE_DIM = 4096;

  localparam int unsigned DIM_W     = 13;
  localparam int unsigned COORD_W   = 16;
  localparam int unsigned STRIDE_W  = 16;
  localparam int unsigned OFFSET_W  = 28;
  localparam int unsigned COLOR_W   = 32;
  localparam int unsigned BLEND_W   = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 32;
  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned CHAN_N    = 4;

  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

  localparam logic ACT_START   = 1'b0;
  localparam logic ACT_ADVANCE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SURFACE_WIDTH  = 3'd0,
    CFG_SURFACE_HEIGHT = 3'd1,
    CFG_ROW_STRIDE     = 3'd2,
    CFG_COLOR_START    = 3'd3,
    CFG_COLOR_END      = 3'd4,
    CFG_BLEND_ORIGIN   = 3'd5,
    CFG_BLEND_STEP_X   = 3'd6,
    CFG_BLEND_STEP_Y   = 3'd7
  } cfg_idx_t;

  // clipped rectangle, right and bottom edges exclusive
  typedef struct packed {
    logic             empty;
    logic [DIM_W-1:0] x0;
    logic [DIM_W-1:0] x1;
    logic [DIM_W-1:0] y0;
    logic [DIM_W-1:0] y1;
  } clip_t;

endpackage

FILE: sv/cgrf_if.sv
// request channel interfaces of the fill core: input, result and configuration
interface cgrf_in_if import cgrf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               action;
  logic [COORD_W-1:0] rect_x;
  logic [COORD_W-1:0] rect_y;
  logic [COORD_W-1:0] rect_width;
  logic [COORD_W-1:0] rect_height;
  logic               gradient_mode;

  modport source (output valid, action, rect_x, rect_y, rect_width, rect_height,
                  gradient_mode, input ready);
  modport sink (input valid, action, rect_x, rect_y, rect_width, rect_height,
                gradient_mode, output ready);
endinterface

interface cgrf_out_if import cgrf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OFFSET_W-1:0] byte_offset;
  logic [COLOR_W-1:0]  pixel_argb;
  logic                write_valid;
  logic                last;

  modport source (output valid, byte_offset, pixel_argb, write_valid, last,
                  input ready);
  modport sink (input valid, byte_offset, pixel_argb, write_valid, last,
                output ready);
endinterface

interface cgrf_cfg_if import cgrf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/cgrf_clip.sv
// clips a start rectangle against the saturated surface size
module cgrf_clip import cgrf_pkg::*; (
  input  logic [COORD_W-1:0] rect_x,
  input  logic [COORD_W-1:0] rect_y,
  input  logic [COORD_W-1:0] rect_width,
  input  logic [COORD_W-1:0] rect_height,
  input  logic [DIM_W-1:0]   surf_w,
  input  logic [DIM_W-1:0]   surf_h,
  output clip_t              clip
);

  localparam int unsigned EXT_W = COORD_W + 2;

  logic [DIM_W-1:0]        sw;
  logic [DIM_W-1:0]        sh;
  logic signed [EXT_W-1:0] rx_s;
  logic signed [EXT_W-1:0] ry_s;
  logic signed [EXT_W-1:0] ex_s;
  logic signed [EXT_W-1:0] ey_s;
  logic signed [EXT_W-1:0] sw_s;
  logic signed [EXT_W-1:0] sh_s;
  logic signed [EXT_W-1:0] x0_s;
  logic signed [EXT_W-1:0] y0_s;
  logic signed [EXT_W-1:0] x1_s;
  logic signed [EXT_W-1:0] y1_s;

  // oversized surface dims saturate
  assign sw = ({1'b0, surf_w} > (DIM_W+1)'(MAX_SURFACE_DIM)) ? DIM_W'(MAX_SURFACE_DIM) : surf_w;
  assign sh = ({1'b0, surf_h} > (DIM_W+1)'(MAX_SURFACE_DIM)) ? DIM_W'(MAX_SURFACE_DIM) : surf_h;

  assign rx_s = $signed({{(EXT_W-COORD_W){rect_x[COORD_W-1]}}, rect_x});
  assign ry_s = $signed({{(EXT_W-COORD_W){rect_y[COORD_W-1]}}, rect_y});
  assign ex_s = rx_s + $signed({{(EXT_W-COORD_W){1'b0}}, rect_width});
  assign ey_s = ry_s + $signed({{(EXT_W-COORD_W){1'b0}}, rect_height});
  assign sw_s = $signed({{(EXT_W-DIM_W){1'b0}}, sw});
  assign sh_s = $signed({{(EXT_W-DIM_W){1'b0}}, sh});

  assign x0_s = rect_x[COORD_W-1] ? '0 : rx_s;
  assign y0_s = rect_y[COORD_W-1] ? '0 : ry_s;
  assign x1_s = (ex_s < sw_s) ? ex_s : sw_s;
  assign y1_s = (ey_s < sh_s) ? ey_s : sh_s;

  always_comb begin
    clip.empty = (x1_s <= x0_s) || (y1_s <= y0_s);
    clip.x0    = x0_s[DIM_W-1:0];
    clip.x1    = x1_s[DIM_W-1:0];
    clip.y0    = y0_s[DIM_W-1:0];
    clip.y1    = y1_s[DIM_W-1:0];
  end

endmodule

FILE: sv/cgrf_mix.sv
// gradient factor from the q16.16 blend value and per-channel colour mix
module cgrf_mix import cgrf_pkg::*; (
  input  logic [BLEND_W-1:0] blend,
  input  logic [COLOR_W-1:0] color_a,
  input  logic [COLOR_W-1:0] color_b,
  output logic [COLOR_W-1:0] pixel
);

  logic [CHAN_W-1:0]            f;
  logic [CHAN_W-1:0]            g;
  logic [3*CHAN_W-1:0]          scaled;
  logic [2*CHAN_W-1:0]          lane [CHAN_N];

  // blend * 255 as shift and subtract on the fraction
  assign scaled = {blend[15:0], {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, blend[15:0]};

  always_comb begin
    if (blend[BLEND_W-1]) begin
      f = '0;
    end else if (blend[BLEND_W-2:16] != '0) begin
      f = CHAN_MAX;
    end else begin
      f = scaled[3*CHAN_W-1:2*CHAN_W];
    end
  end

  assign g = CHAN_MAX - f;

  always_comb begin
    for (int ch = 0; ch < CHAN_N; ch++) begin
      lane[ch] = (2*CHAN_W)'(color_a[ch*CHAN_W +: CHAN_W]) * (2*CHAN_W)'(g)
               + (2*CHAN_W)'(color_b[ch*CHAN_W +: CHAN_W]) * (2*CHAN_W)'(f);
      pixel[ch*CHAN_W +: CHAN_W] = lane[ch][2*CHAN_W-1:CHAN_W];
    end
  end

endmodule

FILE: sv/clipped_gradient_rect_fill_core.sv
// top level of the clipped gradient rectangle fill core
//
// usage
// - cfg_ch: register write requests (index, data), always ready; write only
//   while no request is in flight
// - in_ch: start requests (action 0) load a rectangle, advance requests
//   (action 1) each produce one pixel write in raster order
// - out_ch: byte offset, argb colour, write_valid and last per result; an
//   empty clip on start gives one result with write_valid 0 and last 1
// - a start with a non-empty clip and an advance while idle give no result
// timing
// - an accepted request is held in the input register and its result is
//   registered in the result register once the result slot frees
// - one request per cycle while results are taken; the pixel walker updates its
//   cursor and blend state in the same cycle, so consecutive advances chain freely
// - a stalled receiver holds the result register; the input register still
//   takes one more request, then ready drops until the result is taken
// reset
// - synchronous active-low rst_n clears the configuration registers, the walker
//   goes idle and both channel registers empty; no clearing pass is needed
`include "clipped_gradient_rect_fill_core_assert.svh"

module clipped_gradient_rect_fill_core import cgrf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  cgrf_cfg_if.sink    cfg_ch,
  cgrf_in_if.sink     in_ch,
  cgrf_out_if.source  out_ch
);

  // configuration registers
  logic [DIM_W-1:0]    surf_w_r;
  logic [DIM_W-1:0]    surf_h_r;
  logic [STRIDE_W-1:0] stride_r;
  logic [COLOR_W-1:0]  color_start_r;
  logic [COLOR_W-1:0]  color_end_r;
  logic [BLEND_W-1:0]  blend_origin_r;
  logic [BLEND_W-1:0]  step_x_r;
  logic [BLEND_W-1:0]  step_y_r;

  // input register
  logic               in_vld_r;
  logic               action_r;
  logic [COORD_W-1:0] rect_x_r;
  logic [COORD_W-1:0] rect_y_r;
  logic [COORD_W-1:0] rect_w_r;
  logic [COORD_W-1:0] rect_h_r;
  logic               gradient_r;

  // walker state
  logic                busy_r, busy_nxt;
  logic                use_grad_r, use_grad_nxt;
  logic [DIM_W-1:0]    clip_left_r, clip_left_nxt;
  logic [DIM_W-1:0]    clip_right_r, clip_right_nxt;
  logic [DIM_W-1:0]    clip_bottom_r, clip_bottom_nxt;
  logic [DIM_W-1:0]    cursor_x_r, cursor_x_nxt;
  logic [DIM_W-1:0]    cursor_y_r, cursor_y_nxt;
  logic [OFFSET_W-1:0] row_offset_r, row_offset_nxt;
  logic [BLEND_W-1:0]  row_blend_r, row_blend_nxt;
  logic [BLEND_W-1:0]  pixel_blend_r, pixel_blend_nxt;

  // result register
  logic                out_vld_r, out_vld_nxt;
  logic [OFFSET_W-1:0] out_offset_r;
  logic [COLOR_W-1:0]  out_pixel_r;
  logic                out_write_r;
  logic                out_last_r;

  logic                proceed;
  logic                fire;
  clip_t               clip;
  logic [COLOR_W-1:0]  mix_pixel;

  logic [DIM_W+STRIDE_W-1:0] start_off_prod;
  logic [BLEND_W-1:0]        start_y_prod;
  logic [BLEND_W-1:0]        start_x_prod;
  logic [BLEND_W-1:0]        start_row_blend;
  logic [BLEND_W-1:0]        left_prod;
  logic [BLEND_W-1:0]        next_row_blend;
  logic [DIM_W:0]            cx_inc;
  logic [DIM_W:0]            cy_inc;
  logic                      row_wrap;
  logic                      rect_done;
  logic [OFFSET_W-1:0]       pix_offset;

  logic                res_vld;
  logic [OFFSET_W-1:0] res_offset;
  logic [COLOR_W-1:0]  res_pixel;
  logic                res_write;
  logic                res_last;

  // ---------------------------------------------------------------- config
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      surf_w_r       <= '0;
      surf_h_r       <= '0;
      stride_r       <= '0;
      color_start_r  <= '0;
      color_end_r    <= '0;
      blend_origin_r <= '0;
      step_x_r       <= '0;
      step_y_r       <= '0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_idx_t'(cfg_ch.index))
        CFG_SURFACE_WIDTH:  surf_w_r       <= cfg_ch.data[DIM_W-1:0];
        CFG_SURFACE_HEIGHT: surf_h_r       <= cfg_ch.data[DIM_W-1:0];
        CFG_ROW_STRIDE:     stride_r       <= cfg_ch.data[STRIDE_W-1:0];
        CFG_COLOR_START:    color_start_r  <= cfg_ch.data[COLOR_W-1:0];
        CFG_COLOR_END:      color_end_r    <= cfg_ch.data[COLOR_W-1:0];
        CFG_BLEND_ORIGIN:   blend_origin_r <= cfg_ch.data[BLEND_W-1:0];
        CFG_BLEND_STEP_X:   step_x_r       <= cfg_ch.data[BLEND_W-1:0];
        CFG_BLEND_STEP_Y:   step_y_r       <= cfg_ch.data[BLEND_W-1:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------- input register
  // the request in the input register moves on whenever the result slot frees
  assign proceed     = !out_vld_r || out_ch.ready;
  assign fire        = in_vld_r && proceed;
  assign in_ch.ready = !in_vld_r || proceed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      action_r   <= in_ch.action;
      rect_x_r   <= in_ch.rect_x;
      rect_y_r   <= in_ch.rect_y;
      rect_w_r   <= in_ch.rect_width;
      rect_h_r   <= in_ch.rect_height;
      gradient_r <= in_ch.gradient_mode;
    end
  end

  // ------------------------------------------------------ start arithmetic
  cgrf_clip u_clip (
    .rect_x      (rect_x_r),
    .rect_y      (rect_y_r),
    .rect_width  (rect_w_r),
    .rect_height (rect_h_r),
    .surf_w      (surf_w_r),
    .surf_h      (surf_h_r),
    .clip        (clip)
  );

  // row start offset and blend at the clipped top-left corner
  assign start_off_prod  = (DIM_W+STRIDE_W)'(clip.y0) * (DIM_W+STRIDE_W)'(stride_r);
  assign start_y_prod    = BLEND_W'(clip.y0) * step_y_r;
  assign start_x_prod    = BLEND_W'(clip.x0) * step_x_r;
  assign start_row_blend = blend_origin_r + start_y_prod;

  // ---------------------------------------------------- advance arithmetic
  // step x is live, so the left-edge term is formed on every row change
  assign left_prod      = BLEND_W'(clip_left_r) * step_x_r;
  assign next_row_blend = row_blend_r + step_y_r;
  assign cx_inc         = {1'b0, cursor_x_r} + 1'b1;
  assign cy_inc         = {1'b0, cursor_y_r} + 1'b1;
  assign row_wrap       = cx_inc >= {1'b0, clip_right_r};
  assign rect_done      = cy_inc >= {1'b0, clip_bottom_r};
  assign pix_offset     = row_offset_r + {{(OFFSET_W-DIM_W-2){1'b0}}, cursor_x_r, 2'b00};

  cgrf_mix u_mix (
    .blend   (pixel_blend_r),
    .color_a (color_start_r),
    .color_b (color_end_r),
    .pixel   (mix_pixel)
  );

  // ------------------------------------------------------------ walker
  always_comb begin
    busy_nxt        = busy_r;
    use_grad_nxt    = use_grad_r;
    clip_left_nxt   = clip_left_r;
    clip_right_nxt  = clip_right_r;
    clip_bottom_nxt = clip_bottom_r;
    cursor_x_nxt    = cursor_x_r;
    cursor_y_nxt    = cursor_y_r;
    row_offset_nxt  = row_offset_r;
    row_blend_nxt   = row_blend_r;
    pixel_blend_nxt = pixel_blend_r;
    res_vld         = 1'b0;
    res_offset      = '0;
    res_pixel       = '0;
    res_write       = 1'b0;
    res_last        = 1'b0;

    if (fire) begin
      if (action_r == ACT_START) begin
        // a start drops any running rectangle
        busy_nxt = 1'b0;
        if (clip.empty) begin
          res_vld  = 1'b1;
          res_last = 1'b1;
        end else begin
          busy_nxt        = 1'b1;
          use_grad_nxt    = gradient_r;
          clip_left_nxt   = clip.x0;
          clip_right_nxt  = clip.x1;
          clip_bottom_nxt = clip.y1;
          cursor_x_nxt    = clip.x0;
          cursor_y_nxt    = clip.y0;
          row_offset_nxt  = start_off_prod[OFFSET_W-1:0];
          row_blend_nxt   = start_row_blend;
          pixel_blend_nxt = start_row_blend + start_x_prod;
        end
      end else if (busy_r) begin
        res_vld    = 1'b1;
        res_write  = 1'b1;
        res_offset = pix_offset;
        res_pixel  = use_grad_r ? mix_pixel : color_start_r;
        if (row_wrap) begin
          cursor_x_nxt    = clip_left_r;
          cursor_y_nxt    = cy_inc[DIM_W-1:0];
          row_offset_nxt  = row_offset_r + OFFSET_W'(stride_r);
          row_blend_nxt   = next_row_blend;
          pixel_blend_nxt = next_row_blend + left_prod;
          if (rect_done) begin
            busy_nxt = 1'b0;
            res_last = 1'b1;
          end
        end else begin
          cursor_x_nxt    = cx_inc[DIM_W-1:0];
          pixel_blend_nxt = pixel_blend_r + step_x_r;
        end
      end
      // advance while idle: dropped, no result
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    use_grad_r    <= use_grad_nxt;
    clip_left_r   <= clip_left_nxt;
    clip_right_r  <= clip_right_nxt;
    clip_bottom_r <= clip_bottom_nxt;
    cursor_x_r    <= cursor_x_nxt;
    cursor_y_r    <= cursor_y_nxt;
    row_offset_r  <= row_offset_nxt;
    row_blend_r   <= row_blend_nxt;
    pixel_blend_r <= pixel_blend_nxt;
  end

  // ------------------------------------------------------- result register
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (proceed) begin
      out_vld_nxt = fire && res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_vld) begin
      out_offset_r <= res_offset;
      out_pixel_r  <= res_pixel;
      out_write_r  <= res_write;
      out_last_r   <= res_last;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.byte_offset = out_offset_r;
  assign out_ch.pixel_argb  = out_pixel_r;
  assign out_ch.write_valid = out_write_r;
  assign out_ch.last        = out_last_r;

  // ------------------------------------------------------------ checks
  // cursor always stays inside the clipped rectangle while walking
  `CGRF_ASSERT_IMP(a_cursor_in_rect, busy_r,
                   (cursor_x_r >= clip_left_r) && (cursor_x_r < clip_right_r) &&
                   (cursor_y_r < clip_bottom_r))
  // a completion without a write is always the last result
  `CGRF_ASSERT_IMP(a_empty_is_last, out_vld_r && !out_write_r, out_last_r)
  // a blocked request stays in the input register
  `CGRF_ASSERT_NXT(a_in_hold, in_vld_r && !proceed, in_vld_r)
  // an empty start leaves the walker idle
  `CGRF_ASSERT_NXT(a_empty_idle, fire && (action_r == ACT_START) && clip.empty, !busy_r)

endmodule

FILE: dv/cgrf_fill_checker.sv
// scoreboard of the fill core: predicts each pixel write and compares it with the result channel
module cgrf_fill_checker import cgrf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  cgrf_cfg_if  cfg_ch,
  cgrf_in_if   in_ch,
  cgrf_out_if  out_ch,
  output int   fail_count,
  output int   pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [COLOR_W-1:0] RB_LANES     = 32'h00ff00ff;
  localparam logic [COLOR_W-1:0] AG_LANES     = 32'hff00ff00;
  localparam logic [BLEND_W-1:0] BLEND_ONE    = 32'h0001_0000;
  localparam int                 REPORT_LIMIT = 10;

  typedef struct packed {
    logic [OFFSET_W-1:0] byte_offset;
    logic [COLOR_W-1:0]  pixel_argb;
    logic                write_valid;
    logic                last;
  } pixel_write_t;

  pixel_write_t expected_writes[$];

  // register copies
  logic [DIM_W-1:0]    surf_w, surf_h;
  logic [STRIDE_W-1:0] stride;
  logic [COLOR_W-1:0]  col_a, col_b;
  logic [BLEND_W-1:0]  origin, step_x, step_y;

  // walker state
  logic                walking, grad_on;
  logic [DIM_W-1:0]    left_edge, right_edge, bottom_edge, cur_x, cur_y;
  logic [OFFSET_W-1:0] row_base;
  logic [BLEND_W-1:0]  row_mix, px_mix;

  function automatic logic [CHAN_W-1:0] ramp_factor(logic [BLEND_W-1:0] b);
    logic [BLEND_W-1:0] scaled;
    if (b[BLEND_W-1]) return '0;
    if (b >= BLEND_ONE) return CHAN_MAX;
    scaled = b * {24'b0, CHAN_MAX};
    return scaled[23:16];
  endfunction

  function automatic logic [COLOR_W-1:0] blend_colors(logic [COLOR_W-1:0] c1, c2,
                                                      logic [CHAN_W-1:0] f);
    logic [COLOR_W-1:0] fw, gw, rb, ag;
    fw = {24'b0, f};
    gw = {24'b0, CHAN_MAX - f};
    rb = (c1 & RB_LANES) * gw + (c2 & RB_LANES) * fw;
    ag = ((c1 & AG_LANES) >> 8) * gw + ((c2 & AG_LANES) >> 8) * fw;
    return ((rb & AG_LANES) >> 8) | (ag & AG_LANES);
  endfunction

  function automatic void note_failure(string what, logic [31:0] want, logic [31:0] got);
    fail_count++;
    if (fail_count <= REPORT_LIMIT)
      $display("%0t: %s mismatch, expected %h got %h", $time, what, want, got);
  endfunction

  task automatic open_rect(logic [COORD_W-1:0] rx_b, ry_b, rw_b, rh_b, logic g);
    int rx, ry, rw, rh, sw, sh, x0, y0, x1, y1;
    logic [BLEND_W-1:0] x0u, y0u;
    rx = $signed(rx_b);
    ry = $signed(ry_b);
    rw = rw_b;
    rh = rh_b;
    sw = (surf_w > MAX_SURFACE_DIM) ? MAX_SURFACE_DIM : surf_w;
    sh = (surf_h > MAX_SURFACE_DIM) ? MAX_SURFACE_DIM : surf_h;
    x0 = (rx > 0) ? rx : 0;
    y0 = (ry > 0) ? ry : 0;
    x1 = (rx + rw < sw) ? rx + rw : sw;
    y1 = (ry + rh < sh) ? ry + rh : sh;
    walking = 1'b0;
    if (x1 <= x0 || y1 <= y0) begin
      expected_writes.push_back('{'0, '0, 1'b0, 1'b1});
      return;
    end
    x0u = x0;
    y0u = y0;
    walking     = 1'b1;
    grad_on     = g;
    left_edge   = x0u[DIM_W-1:0];
    right_edge  = x1[DIM_W-1:0];
    bottom_edge = y1[DIM_W-1:0];
    cur_x       = x0u[DIM_W-1:0];
    cur_y       = y0u[DIM_W-1:0];
    row_base    = y0u * stride;
    row_mix     = origin + y0u * step_y;
    px_mix      = row_mix + x0u * step_x;
  endtask

  task automatic step_cursor();
    logic [OFFSET_W-1:0] off;
    logic [COLOR_W-1:0]  px;
    logic                fin;
    if (!walking) return;
    off = row_base + {cur_x, 2'b00};
    px  = grad_on ? blend_colors(col_a, col_b, ramp_factor(px_mix)) : col_a;
    fin = 1'b0;
    cur_x  = cur_x + 1'b1;
    px_mix = px_mix + step_x;
    if (cur_x >= right_edge) begin
      cur_x    = left_edge;
      cur_y    = cur_y + 1'b1;
      row_base = row_base + stride;
      row_mix  = row_mix + step_y;
      px_mix   = row_mix + {19'b0, left_edge} * step_x;
      if (cur_y >= bottom_edge) begin
        walking = 1'b0;
        fin     = 1'b1;
      end
    end
    expected_writes.push_back('{off, px, 1'b1, fin});
  endtask

  task automatic check_write();
    pixel_write_t got, want;
    got = '{out_ch.byte_offset, out_ch.pixel_argb, out_ch.write_valid, out_ch.last};
    if (expected_writes.size() == 0) begin
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
        $display("%0t: result with none expected, offset %h value %h write %b last %b",
                 $time, got.byte_offset, got.pixel_argb, got.write_valid, got.last);
      return;
    end
    want = expected_writes.pop_front();
    if (got.byte_offset !== want.byte_offset)
      note_failure("byte_offset", want.byte_offset, got.byte_offset);
    if (got.pixel_argb !== want.pixel_argb)
      note_failure("pixel_argb", want.pixel_argb, got.pixel_argb);
    if (got.write_valid !== want.write_valid)
      note_failure("write_valid", want.write_valid, got.write_valid);
    if (got.last !== want.last)
      note_failure("last", want.last, got.last);
  endtask

  task automatic write_register(cfg_idx_t idx, logic [CFG_DAT_W-1:0] data);
    case (idx)
      CFG_SURFACE_WIDTH:  surf_w = data[DIM_W-1:0];
      CFG_SURFACE_HEIGHT: surf_h = data[DIM_W-1:0];
      CFG_ROW_STRIDE:     stride = data[STRIDE_W-1:0];
      CFG_COLOR_START:    col_a  = data;
      CFG_COLOR_END:      col_b  = data;
      CFG_BLEND_ORIGIN:   origin = data;
      CFG_BLEND_STEP_X:   step_x = data;
      CFG_BLEND_STEP_Y:   step_y = data;
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      {surf_w, surf_h, stride, col_a, col_b, origin, step_x, step_y} = '0;
      {walking, grad_on, left_edge, right_edge, bottom_edge, cur_x, cur_y} = '0;
      {row_base, row_mix, px_mix} = '0;
      expected_writes.delete();
    end else begin
      // results are compared before this edge's request can add an expectation
      if (out_ch.valid && out_ch.ready) check_write();
      if (cfg_ch.valid && cfg_ch.ready) write_register(cfg_idx_t'(cfg_ch.index), cfg_ch.data);
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.action == ACT_START)
          open_rect(in_ch.rect_x, in_ch.rect_y, in_ch.rect_width, in_ch.rect_height,
                    in_ch.gradient_mode);
        else
          step_cursor();
      end
    end
    pending_count <= expected_writes.size();
  end

endmodule

FILE: dv/tb_clipped_gradient_rect_fill_core.sv
// top of the fill core testbench: clock, reset, register phases, request stimulus and verdict
module tb_clipped_gradient_rect_fill_core import cgrf_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // cycles without any accepted request before the run is declared hung
  localparam int QUIET_LIMIT  = 5000;
  // request pipeline is two deep, so these settle ticks cover a request with no result
  localparam int SETTLE_TICKS = 4;
  localparam int PHASES       = 8;
  localparam int ITEM_TARGET  = 1900;
  // clipped areas above this are replaced by small ones to keep the run short
  localparam int AREA_CAP     = 512;

  typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_QUARTER, RX_TRICKLE} rx_pattern_t;

  logic clk = 1'b0;
  logic rst_n;

  cgrf_cfg_if cfg_ch ();
  cgrf_in_if  in_ch ();
  cgrf_out_if out_ch ();

  int check_fails;
  int check_pending;

  clipped_gradient_rect_fill_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  cgrf_fill_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_ch        (cfg_ch),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_count    (check_fails),
    .pending_count (check_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // surface size as last written, needed to know how many advances a rectangle takes
  logic [DIM_W-1:0] sw_cfg, sh_cfg;
  // pixels still owed by the open rectangle; an advance with none owed is ignored
  int left_px;
  int items_sent;
  int burst_left;

  // receiver: switches at random between stall patterns
  rx_pattern_t rx_pattern;
  int          rx_left;

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_pattern = rx_pattern_t'($urandom_range(0, 3));
      rx_left    = $urandom_range(20, 200);
    end
    rx_left--;
    case (rx_pattern)
      RX_FREE:    out_ch.ready <= 1'b1;
      RX_COIN:    out_ch.ready <= ($urandom_range(0, 1) == 1);
      RX_QUARTER: out_ch.ready <= (rx_left % 4 == 0);
      default:    out_ch.ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // watchdog: any accepted request on any channel restarts the count
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  // clipped pixel count of a rectangle under the current surface size
  function automatic int clip_area(int x, int y, int w, int h);
    int sw, sh, x0, y0, x1, y1;
    sw = (sw_cfg > MAX_SURFACE_DIM) ? MAX_SURFACE_DIM : sw_cfg;
    sh = (sh_cfg > MAX_SURFACE_DIM) ? MAX_SURFACE_DIM : sh_cfg;
    x0 = (x > 0) ? x : 0;
    y0 = (y > 0) ? y : 0;
    x1 = (x + w < sw) ? x + w : sw;
    y1 = (y + h < sh) ? y + h : sh;
    if (x1 <= x0 || y1 <= y0) return 0;
    return (x1 - x0) * (y1 - y0);
  endfunction

  // small rectangle around the surface, now and then one at the coordinate extremes
  function automatic void pick_rect(output int x, y, w, h);
    int sw, sh;
    sw = (sw_cfg > MAX_SURFACE_DIM) ? MAX_SURFACE_DIM : sw_cfg;
    sh = (sh_cfg > MAX_SURFACE_DIM) ? MAX_SURFACE_DIM : sh_cfg;
    x = int'($urandom_range(0, sw + 6)) - 4;
    y = int'($urandom_range(0, sh + 6)) - 4;
    w = $urandom_range(0, 9);
    h = $urandom_range(0, 6);
    case ($urandom_range(0, 11))
      0: begin
        x = -32768;
        w = 65535;
      end
      1: begin
        y = -32768;
        h = 65535;
      end
      2: x = 32767;
      3: y = 32767;
      4: w = 0;
      5: h = 0;
      default: ;
    endcase
    if (clip_area(x, y, w, h) > AREA_CAP) begin
      w = $urandom_range(1, 8);
      h = $urandom_range(1, 4);
    end
  endfunction

  // one request on the input channel; the sender may idle between bursts
  task automatic send_request(input logic act, input logic [COORD_W-1:0] x, y, w, h,
                              input logic g, input bit counts);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_ch.valid         <= 1'b1;
    in_ch.action        <= act;
    in_ch.rect_x        <= x;
    in_ch.rect_y        <= y;
    in_ch.rect_width    <= w;
    in_ch.rect_height   <= h;
    in_ch.gradient_mode <= g;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (counts) items_sent++;
    @(negedge clk);
  endtask

  task automatic start_rect(int x, y, w, h, logic g);
    send_request(ACT_START, 16'(x), 16'(y), 16'(w), 16'(h), g, 1'b1);
    left_px = clip_area(x, y, w, h);
  endtask

  // advance requests carry junk in the rectangle fields, which the block ignores
  task automatic advance_px();
    send_request(ACT_ADVANCE, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                 1'($urandom), left_px > 0);
    if (left_px > 0) left_px--;
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DAT_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_all(logic [DIM_W-1:0] w, h, logic [STRIDE_W-1:0] stride,
                           logic [COLOR_W-1:0] cs, ce, logic [BLEND_W-1:0] org, sx, sy);
    sw_cfg = w;
    sh_cfg = h;
    write_reg(CFG_SURFACE_WIDTH, 32'(w));
    write_reg(CFG_SURFACE_HEIGHT, 32'(h));
    write_reg(CFG_ROW_STRIDE, 32'(stride));
    write_reg(CFG_COLOR_START, cs);
    write_reg(CFG_COLOR_END, ce);
    write_reg(CFG_BLEND_ORIGIN, org);
    write_reg(CFG_BLEND_STEP_X, sx);
    write_reg(CFG_BLEND_STEP_Y, sy);
    cfg_ch.valid <= 1'b0;
  endtask

  // wait for every expected result, then let the pipeline empty
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (check_pending != 0) @(negedge clk);
    repeat (SETTLE_TICKS) @(negedge clk);
  endtask

  // blend values that sweep the factor through its range over a few pixels
  function automatic logic [BLEND_W-1:0] gentle_origin();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return 32'($urandom_range(0, 32'h40000)) - 32'h10000;
  endfunction

  function automatic logic [BLEND_W-1:0] gentle_step();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return 32'($urandom_range(0, 32'h8000)) - 32'h4000;
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    if ($urandom_range(0, 3) == 0) return $urandom_range(1, MAX_SURFACE_DIM);
    return $urandom_range(1, 20);
  endfunction

  // register setting of each phase, extremes first
  task automatic load_phase(int p);
    case (p)
      0: write_all(13'd0, 13'd5, 16'($urandom), $urandom, $urandom,
                   gentle_origin(), gentle_step(), gentle_step());
      1: write_all(13'd4096, 13'd4096, 16'hffff, 32'hffffffff, 32'h0,
                   32'h7fffffff, 32'h80000000, 32'h7fffffff);
      2: write_all(13'd1, 13'd1, 16'h0, 32'h0, 32'hffffffff, 32'h80000000, 32'h0, 32'h0);
      3: write_all(13'd8191, 13'd4097, 16'($urandom), $urandom, $urandom,
                   gentle_origin(), gentle_step(), gentle_step());
      4: write_all(13'd7, 13'd0, 16'($urandom), $urandom, $urandom,
                   gentle_origin(), gentle_step(), gentle_step());
      default: write_all(pick_dim(), pick_dim(), 16'($urandom), $urandom, $urandom,
                         gentle_origin(), gentle_step(), gentle_step());
    endcase
  endtask

  // mostly whole rectangles; the rest are cut short, empty, random or stray advances
  task automatic run_sequence();
    int   x, y, w, h, k, sel;
    logic g;
    sel = $urandom_range(0, 19);
    g   = 1'($urandom);
    if (sel < 14) begin
      pick_rect(x, y, w, h);
      start_rect(x, y, w, h, g);
      while (left_px > 0) advance_px();
    end else if (sel < 16) begin
      // fully random fields, usually a huge area that the next start drops
      x = int'($urandom_range(0, 65535)) - 32768;
      y = int'($urandom_range(0, 65535)) - 32768;
      w = $urandom_range(0, 65535);
      h = $urandom_range(0, 65535);
      start_rect(x, y, w, h, g);
      k = (left_px < 6) ? left_px : 6;
      repeat ($urandom_range(0, k)) advance_px();
    end else if (sel == 16) begin
      pick_rect(x, y, w, h);
      start_rect(x, y, w, h, g);
      if (left_px > 0) repeat ($urandom_range(0, left_px - 1)) advance_px();
    end else if (sel == 17) begin
      pick_rect(x, y, w, h);
      case ($urandom_range(0, 2))
        0: w = 0;
        1: h = 0;
        default: x = (sw_cfg > MAX_SURFACE_DIM ? MAX_SURFACE_DIM : sw_cfg)
                     + $urandom_range(0, 100);
      endcase
      start_rect(x, y, w, h, g);
    end else begin
      advance_px();
    end
  endtask

  initial begin
    int quota;
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.action        = ACT_START;
    in_ch.rect_x        = '0;
    in_ch.rect_y        = '0;
    in_ch.rect_width    = '0;
    in_ch.rect_height   = '0;
    in_ch.gradient_mode = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = CFG_SURFACE_WIDTH;
    cfg_ch.data         = '0;
    out_ch.ready        = 1'b0;
    sw_cfg              = '0;
    sh_cfg              = '0;
    left_px             = 0;
    items_sent          = 0;
    burst_left          = 0;
    rx_left             = 0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: oversized width saturates, blend goes from negative through mid to above one
    write_all(13'd8191, 13'd4096, 16'hffff, 32'h80ff017f, 32'h7f00fe80,
              32'hffff8000, 32'h00008000, 32'h0);
    // bottom right corner from far outside, offset at its largest
    start_rect(4093, 4095, 65535, 65535, 1'b1);
    repeat (3) advance_px();
    // factor zero, zero and half along one row
    start_rect(0, 0, 3, 1, 1'b1);
    repeat (3) advance_px();
    // empty clips: zero width, right of the surface, zero height, above the surface
    start_rect(5, 5, 0, 3, 1'b0);
    start_rect(32767, 0, 4, 4, 1'b0);
    start_rect(-32768, 0, 65535, 0, 1'b1);
    start_rect(0, -32768, 2, 32768, 1'b0);
    // advance with nothing open is ignored
    advance_px();
    // solid rectangle dropped halfway by a new gradient one
    start_rect(-2, 1, 4, 2, 1'b0);
    repeat (2) advance_px();
    start_rect(1, 2, 2, 1, 1'b1);
    repeat (2) advance_px();

    // random phases, each under its own register setting
    for (int p = 0; p < PHASES; p++) begin
      settle();
      load_phase(p);
      quota = items_sent + ITEM_TARGET / PHASES;
      while (items_sent < quota) run_sequence();
    end

    settle();
    if (check_fails == 0 && check_pending == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
